/* hdl/ble_adv_field_extractor_assert.svh */
// ----------------------------------------------------------------------------
// BLE advertising field extractor assertion macros
// Shared concurrent assertion forms. Both sample on clk and stay quiet in rst.
// ----------------------------------------------------------------------------
`ifndef BLE_ADV_FIELD_EXTRACTOR_ASSERT_SVH
`define BLE_ADV_FIELD_EXTRACTOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLE_AFX_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ble_afx same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define BLE_AFX_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ble_afx next-cycle check failed");

`endif

/* hdl/ble_afx_pkg.sv */
// ----------------------------------------------------------------------------
// ble_afx_pkg
// Types and constants shared by the BLE advertising field extractor.
// ----------------------------------------------------------------------------
package ble_afx_pkg;

  localparam int MAX_PAYLOAD_BYTES = 255;
  localparam int POS_W = 8;

  localparam logic [7:0] NAME_MAX_LEN_RESET = 8'd31;

  // AD structure type codes.
  localparam logic [7:0] KIND_UUID16_PART     = 8'h02;
  localparam logic [7:0] KIND_UUID16_FULL     = 8'h03;
  localparam logic [7:0] KIND_UUID32_PART     = 8'h04;
  localparam logic [7:0] KIND_UUID32_FULL     = 8'h05;
  localparam logic [7:0] KIND_UUID128_PART    = 8'h06;
  localparam logic [7:0] KIND_UUID128_FULL    = 8'h07;
  localparam logic [7:0] KIND_SHORT_NAME      = 8'h08;
  localparam logic [7:0] KIND_COMPLETE_NAME   = 8'h09;
  localparam logic [7:0] KIND_TX_POWER        = 8'h0A;
  localparam logic [7:0] KIND_SVC_DATA16      = 8'h16;
  localparam logic [7:0] KIND_SVC_DATA32      = 8'h20;
  localparam logic [7:0] KIND_SVC_DATA128     = 8'h21;
  localparam logic [7:0] KIND_MANUFACTURER    = 8'hFF;

  localparam logic [15:0] MFG_ID_NONE = 16'hFFFF;

  // Name selection codes.
  localparam logic [1:0] NAME_NONE     = 2'd0;
  localparam logic [1:0] NAME_SHORT    = 2'd1;
  localparam logic [1:0] NAME_COMPLETE = 2'd2;

  localparam logic [6:0] COUNT7_MAX = 7'd127;
  localparam logic [3:0] COUNT4_MAX = 4'd15;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [7:0] tx_power;
    logic [15:0]       manufacturer_id;
    logic [6:0]        metric_count;
    logic              has_service;
    logic [6:0]        uuid16_count;
    logic [3:0]        uuid128_count;
    logic [1:0]        name_kind;
    logic [7:0]        name_offset;
    logic [7:0]        name_len;
    logic [7:0]        mfg_payload_offset;
    logic [7:0]        mfg_payload_len;
  } out_word_t;

endpackage

/* hdl/ble_afx_parser.sv */
// ----------------------------------------------------------------------------
// ble_afx_parser
// Walks length/type/value structures one byte per in_fire cycle, accumulates
// the packet summary and presents it on the cycle that carries the last byte.
// ----------------------------------------------------------------------------
module ble_afx_parser
  import ble_afx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  in_word_t   in_word,
  input  logic [7:0] name_max_len,
  output logic       res_valid,
  output out_word_t  res_word
);

  `include "ble_adv_field_extractor_assert.svh"

  typedef enum logic [3:0] {
    PH_LEN   = 4'b0001,
    PH_TYPE  = 4'b0010,
    PH_VALUE = 4'b0100,
    PH_HALT  = 4'b1000
  } phase_t;

  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_PAYLOAD_BYTES);

  phase_t           phase, phase_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       field_length, field_length_next;
  logic [7:0]       field_kind, field_kind_next;
  logic [7:0]       bytes_left, bytes_left_next;
  logic [7:0]       value_start, value_start_next;
  logic [7:0]       first_value_byte, first_value_byte_next;
  logic [7:0]       second_value_byte, second_value_byte_next;
  logic [7:0]       held_tx_power, held_tx_power_next;
  logic [15:0]      held_manufacturer, held_manufacturer_next;
  logic [6:0]       held_metric_count, held_metric_count_next;
  logic             held_service_flag, held_service_flag_next;
  logic [6:0]       held_uuid16_count, held_uuid16_count_next;
  logic [3:0]       held_uuid128_count, held_uuid128_count_next;
  logic [1:0]       held_name_kind, held_name_kind_next;
  logic [7:0]       held_name_offset, held_name_offset_next;
  logic [7:0]       held_name_length, held_name_length_next;
  logic [7:0]       held_mfg_offset, held_mfg_offset_next;
  logic [7:0]       held_mfg_length, held_mfg_length_next;

  logic       commit;
  logic [7:0] vlen;
  logic [7:0] value_idx;
  logic [7:0] uuid16_sum;
  logic [4:0] uuid128_sum;
  logic       in_range;

  assign vlen     = field_length - 8'd1;
  assign in_range = byte_position < POS_LIMIT;

  always_comb begin
    phase_next              = phase;
    byte_position_next      = byte_position;
    field_length_next       = field_length;
    field_kind_next         = field_kind;
    bytes_left_next         = bytes_left;
    value_start_next        = value_start;
    first_value_byte_next   = first_value_byte;
    second_value_byte_next  = second_value_byte;
    held_tx_power_next      = held_tx_power;
    held_manufacturer_next  = held_manufacturer;
    held_metric_count_next  = held_metric_count;
    held_service_flag_next  = held_service_flag;
    held_uuid16_count_next  = held_uuid16_count;
    held_uuid128_count_next = held_uuid128_count;
    held_name_kind_next     = held_name_kind;
    held_name_offset_next   = held_name_offset;
    held_name_length_next   = held_name_length;
    held_mfg_offset_next    = held_mfg_offset;
    held_mfg_length_next    = held_mfg_length;
    commit                  = 1'b0;
    value_idx               = vlen - bytes_left;
    uuid16_sum              = 8'd0;
    uuid128_sum             = 5'd0;

    if (in_fire) begin
      if (!in_range) begin
        phase_next = PH_HALT;
      end else begin
        byte_position_next = byte_position + POS_W'(1);
        unique case (phase)
          PH_LEN: begin
            if (in_word.data_byte == 8'd0) begin
              phase_next = PH_HALT;
            end else begin
              field_length_next = in_word.data_byte;
              phase_next        = PH_TYPE;
            end
          end
          PH_TYPE: begin
            field_kind_next        = in_word.data_byte;
            bytes_left_next        = vlen;
            value_start_next       = byte_position + 8'd1;
            first_value_byte_next  = 8'd0;
            second_value_byte_next = 8'd0;
            if (vlen == 8'd0) begin
              commit     = 1'b1;
              phase_next = PH_LEN;
            end else begin
              phase_next = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (value_idx == 8'd0) begin
              first_value_byte_next = in_word.data_byte;
            end else if (value_idx == 8'd1) begin
              second_value_byte_next = in_word.data_byte;
            end
            bytes_left_next = bytes_left - 8'd1;
            if (bytes_left_next == 8'd0) begin
              commit     = 1'b1;
              phase_next = PH_LEN;
            end
          end
          PH_HALT: begin
          end
          default: begin
            phase_next = PH_HALT;
          end
        endcase
      end
    end

    // A structure only counts once its final byte is in.
    if (commit) begin
      case (field_kind_next)
        KIND_COMPLETE_NAME: begin
          if (held_name_kind != NAME_COMPLETE) begin
            held_name_kind_next   = NAME_COMPLETE;
            held_name_offset_next = value_start_next;
            held_name_length_next = vlen;
          end
        end
        KIND_SHORT_NAME: begin
          if (held_name_kind != NAME_COMPLETE) begin
            held_name_kind_next   = NAME_SHORT;
            held_name_offset_next = value_start_next;
            held_name_length_next = vlen;
          end
        end
        KIND_TX_POWER: begin
          if (vlen >= 8'd1) begin
            held_tx_power_next     = first_value_byte_next;
            held_metric_count_next = (held_metric_count == COUNT7_MAX) ?
                                     COUNT7_MAX : held_metric_count + 7'd1;
          end
        end
        KIND_MANUFACTURER: begin
          if (vlen >= 8'd2) begin
            held_manufacturer_next = {second_value_byte_next, first_value_byte_next};
            held_mfg_offset_next   = value_start_next + 8'd2;
            held_mfg_length_next   = vlen - 8'd2;
            held_metric_count_next = (held_metric_count == COUNT7_MAX) ?
                                     COUNT7_MAX : held_metric_count + 7'd1;
          end
        end
        KIND_UUID16_PART, KIND_UUID16_FULL: begin
          held_service_flag_next = 1'b1;
          uuid16_sum             = {1'b0, held_uuid16_count} + {1'b0, vlen[7:1]};
          held_uuid16_count_next = (uuid16_sum > {1'b0, COUNT7_MAX}) ?
                                   COUNT7_MAX : uuid16_sum[6:0];
        end
        KIND_SVC_DATA16: begin
          if (vlen >= 8'd2) begin
            held_service_flag_next = 1'b1;
            held_uuid16_count_next = (held_uuid16_count == COUNT7_MAX) ?
                                     COUNT7_MAX : held_uuid16_count + 7'd1;
          end
        end
        KIND_UUID128_PART, KIND_UUID128_FULL: begin
          held_service_flag_next  = 1'b1;
          uuid128_sum             = {1'b0, held_uuid128_count} + {1'b0, vlen[7:4]};
          held_uuid128_count_next = (uuid128_sum > {1'b0, COUNT4_MAX}) ?
                                    COUNT4_MAX : uuid128_sum[3:0];
        end
        KIND_SVC_DATA128: begin
          if (vlen >= 8'd16) begin
            held_service_flag_next  = 1'b1;
            held_uuid128_count_next = (held_uuid128_count == COUNT4_MAX) ?
                                      COUNT4_MAX : held_uuid128_count + 4'd1;
          end
        end
        KIND_UUID32_PART, KIND_UUID32_FULL, KIND_SVC_DATA32: begin
          if (vlen >= 8'd4) begin
            held_service_flag_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    res_valid                   = in_fire && in_word.last_byte;
    res_word.tx_power           = $signed(held_tx_power_next);
    res_word.manufacturer_id    = held_manufacturer_next;
    res_word.metric_count       = held_metric_count_next;
    res_word.has_service        = held_service_flag_next;
    res_word.uuid16_count       = held_uuid16_count_next;
    res_word.uuid128_count      = held_uuid128_count_next;
    res_word.name_kind          = held_name_kind_next;
    res_word.name_offset        = held_name_offset_next;
    res_word.name_len           = (held_name_length_next < name_max_len) ?
                                  held_name_length_next : name_max_len;
    res_word.mfg_payload_offset = held_mfg_offset_next;
    res_word.mfg_payload_len    = held_mfg_length_next;

    // The summary has been taken; start the next packet from scratch.
    if (res_valid) begin
      phase_next              = PH_LEN;
      byte_position_next      = '0;
      field_length_next       = 8'd0;
      field_kind_next         = 8'd0;
      bytes_left_next         = 8'd0;
      value_start_next        = 8'd0;
      first_value_byte_next   = 8'd0;
      second_value_byte_next  = 8'd0;
      held_tx_power_next      = 8'd0;
      held_manufacturer_next  = MFG_ID_NONE;
      held_metric_count_next  = 7'd0;
      held_service_flag_next  = 1'b0;
      held_uuid16_count_next  = 7'd0;
      held_uuid128_count_next = 4'd0;
      held_name_kind_next     = NAME_NONE;
      held_name_offset_next   = 8'd0;
      held_name_length_next   = 8'd0;
      held_mfg_offset_next    = 8'd0;
      held_mfg_length_next    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase              <= PH_LEN;
      byte_position      <= '0;
      field_length       <= 8'd0;
      field_kind         <= 8'd0;
      bytes_left         <= 8'd0;
      value_start        <= 8'd0;
      first_value_byte   <= 8'd0;
      second_value_byte  <= 8'd0;
      held_tx_power      <= 8'd0;
      held_manufacturer  <= MFG_ID_NONE;
      held_metric_count  <= 7'd0;
      held_service_flag  <= 1'b0;
      held_uuid16_count  <= 7'd0;
      held_uuid128_count <= 4'd0;
      held_name_kind     <= NAME_NONE;
      held_name_offset   <= 8'd0;
      held_name_length   <= 8'd0;
      held_mfg_offset    <= 8'd0;
      held_mfg_length    <= 8'd0;
    end else begin
      phase              <= phase_next;
      byte_position      <= byte_position_next;
      field_length       <= field_length_next;
      field_kind         <= field_kind_next;
      bytes_left         <= bytes_left_next;
      value_start        <= value_start_next;
      first_value_byte   <= first_value_byte_next;
      second_value_byte  <= second_value_byte_next;
      held_tx_power      <= held_tx_power_next;
      held_manufacturer  <= held_manufacturer_next;
      held_metric_count  <= held_metric_count_next;
      held_service_flag  <= held_service_flag_next;
      held_uuid16_count  <= held_uuid16_count_next;
      held_uuid128_count <= held_uuid128_count_next;
      held_name_kind     <= held_name_kind_next;
      held_name_offset   <= held_name_offset_next;
      held_name_length   <= held_name_length_next;
      held_mfg_offset    <= held_mfg_offset_next;
      held_mfg_length    <= held_mfg_length_next;
    end
  end

  `BLE_AFX_ASSERT_SAME(a_commit_in_field, commit,
    (phase == PH_TYPE || phase == PH_VALUE) && in_fire && in_range)
  `BLE_AFX_ASSERT_SAME(a_pos_bounded, 1'b1, byte_position <= POS_LIMIT)
  `BLE_AFX_ASSERT_NEXT(a_clear_after_last, res_valid,
    byte_position == '0 && phase == PH_LEN && held_name_kind == NAME_NONE)

endmodule

/* hdl/ble_adv_field_extractor.sv */
// The summary word is registered into out_word, or into the skid register if out_word is held.
// Throughput: one byte per cycle while in_stall is low; a single parser pass per byte.
// A second summary arriving while the first is stalled waits in a one-word skid register;
// the input stalls only while that skid register is occupied.
// Reset (rst, synchronous, active high) clears all parse state, empties the output
// stages and sets name_max_len to 31.
// ----------------------------------------------------------------------------
// ble_adv_field_extractor
// BLE advertising payload field extractor with a registered, skid-buffered
// summary output and a single name length limit register.
// ----------------------------------------------------------------------------
module ble_adv_field_extractor
  import ble_afx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  `include "ble_adv_field_extractor_assert.svh"

  logic [7:0] name_limit;
  logic       in_fire;
  logic       out_pop;
  logic       res_valid;
  out_word_t  res_word;
  logic       skid_valid;
  out_word_t  skid_word;

  assign in_stall     = skid_valid;
  assign in_fire      = in_valid && !in_stall;
  assign out_pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= NAME_MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      name_limit <= cfg_wr_data;
    end
  end

  ble_afx_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .in_fire      (in_fire),
    .in_word      (in_word),
    .name_max_len (name_limit),
    .res_valid    (res_valid),
    .res_word     (res_word)
  );

  // Output register with a one-word skid stage behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_pop) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid || out_pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_pop) begin
        out_word <= skid_word;
      end
    end else if (res_valid) begin
      if (!out_valid || out_pop) begin
        out_word <= res_word;
      end else begin
        skid_word <= res_word;
      end
    end
  end

  `BLE_AFX_ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `BLE_AFX_ASSERT_NEXT(a_skid_fills, res_valid && out_valid && out_stall,
    skid_valid && out_valid)
  `BLE_AFX_ASSERT_NEXT(a_skid_drains, skid_valid && !out_stall,
    out_valid && !skid_valid)

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ble_adv_field_extractor. The bench streams whole
// advertising payloads into the block: directed packets, name limit sweeps,
// packets at and past the 255 byte parse limit, back-to-back short packets
// and random well-formed, truncated and noise packets. A local model of the
// parser predicts each summary word, and every summary that leaves the block
// is compared field by field.
// ----------------------------------------------------------------------------
module tb;
  import ble_afx_pkg::*;

  localparam int ITEM_TARGET  = 1850;
  localparam int MAX_GAP      = 16;
  localparam int DRAIN_CYCLES = 4;
  localparam int QUIET_LIMIT  = 2000;

  typedef enum logic [1:0] {SEEK_LEN, SEEK_KIND, IN_VALUE, HALTED} walk_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  ble_adv_field_extractor dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Parser model state.
  logic [7:0] name_limit;
  int         walk_pos;
  walk_t      walk;
  logic [7:0] fld_len;
  logic [7:0] fld_kind;
  logic [7:0] fld_left;
  logic [7:0] fld_start;
  logic [7:0] fld_b0;
  logic [7:0] fld_b1;
  // The name_len field holds the unclamped length until the summary is taken.
  out_word_t  held;
  out_word_t  summary_q[$];

  logic [7:0] pkt_q[$];
  logic       feed_paced = 1'b1;
  logic       sink_paced = 1'b1;
  int         bytes_sent = 0;
  int         packets_sent = 0;
  int         results_checked = 0;
  int         cfg_writes = 0;
  int         error_count = 0;
  int         quiet_cycles = 0;

  function automatic void clear_walk();
    walk_pos  = 0;
    walk      = SEEK_LEN;
    fld_len   = '0;
    fld_kind  = '0;
    fld_left  = '0;
    fld_start = '0;
    fld_b0    = '0;
    fld_b1    = '0;
    held      = '0;
    held.manufacturer_id = MFG_ID_NONE;
  endfunction

  function automatic int sat_add(int a, int b, int lim);
    return (a + b > lim) ? lim : a + b;
  endfunction

  function automatic void commit_field();
    logic [7:0] vlen;
    vlen = fld_len - 8'd1;
    case (fld_kind)
      KIND_COMPLETE_NAME: begin
        if (held.name_kind != NAME_COMPLETE) begin
          held.name_kind   = NAME_COMPLETE;
          held.name_offset = fld_start;
          held.name_len    = vlen;
        end
      end
      KIND_SHORT_NAME: begin
        if (held.name_kind != NAME_COMPLETE) begin
          held.name_kind   = NAME_SHORT;
          held.name_offset = fld_start;
          held.name_len    = vlen;
        end
      end
      KIND_TX_POWER: begin
        if (vlen >= 1) begin
          held.tx_power     = fld_b0;
          held.metric_count = 7'(sat_add(held.metric_count, 1, COUNT7_MAX));
        end
      end
      KIND_MANUFACTURER: begin
        if (vlen >= 2) begin
          held.manufacturer_id    = {fld_b1, fld_b0};
          held.mfg_payload_offset = fld_start + 8'd2;
          held.mfg_payload_len    = vlen - 8'd2;
          held.metric_count       = 7'(sat_add(held.metric_count, 1, COUNT7_MAX));
        end
      end
      KIND_UUID16_PART, KIND_UUID16_FULL: begin
        held.has_service  = 1'b1;
        held.uuid16_count = 7'(sat_add(held.uuid16_count, vlen / 2, COUNT7_MAX));
      end
      KIND_SVC_DATA16: begin
        if (vlen >= 2) begin
          held.has_service  = 1'b1;
          held.uuid16_count = 7'(sat_add(held.uuid16_count, 1, COUNT7_MAX));
        end
      end
      KIND_UUID128_PART, KIND_UUID128_FULL: begin
        held.has_service   = 1'b1;
        held.uuid128_count = 4'(sat_add(held.uuid128_count, vlen / 16, COUNT4_MAX));
      end
      KIND_SVC_DATA128: begin
        if (vlen >= 16) begin
          held.has_service   = 1'b1;
          held.uuid128_count = 4'(sat_add(held.uuid128_count, 1, COUNT4_MAX));
        end
      end
      KIND_UUID32_PART, KIND_UUID32_FULL, KIND_SVC_DATA32: begin
        if (vlen >= 4) held.has_service = 1'b1;
      end
      default: ;
    endcase
  endfunction

  // Advances the model by one accepted word and queues the summary on the last one.
  function automatic void absorb_byte(logic [7:0] b, logic last);
    out_word_t  summary;
    logic [7:0] idx;
    if (walk_pos >= MAX_PAYLOAD_BYTES) begin
      walk = HALTED;
    end else begin
      case (walk)
        SEEK_LEN: begin
          if (b == 8'd0) begin
            walk = HALTED;
          end else begin
            fld_len = b;
            walk    = SEEK_KIND;
          end
        end
        SEEK_KIND: begin
          fld_kind  = b;
          fld_left  = fld_len - 8'd1;
          fld_start = 8'(walk_pos + 1);
          fld_b0    = '0;
          fld_b1    = '0;
          if (fld_left == 8'd0) begin
            commit_field();
            walk = SEEK_LEN;
          end else begin
            walk = IN_VALUE;
          end
        end
        IN_VALUE: begin
          idx = fld_len - 8'd1 - fld_left;
          if (idx == 8'd0) fld_b0 = b;
          else if (idx == 8'd1) fld_b1 = b;
          fld_left = fld_left - 8'd1;
          if (fld_left == 8'd0) begin
            commit_field();
            walk = SEEK_LEN;
          end
        end
        default: ;
      endcase
      walk_pos++;
    end
    if (last) begin
      summary = held;
      if (held.name_len > name_limit) summary.name_len = name_limit;
      summary_q.push_back(summary);
      clear_walk();
    end
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic void compare_field(string label, logic [15:0] want, logic [15:0] got);
    if (got !== want)
      note_error($sformatf("summary %0d field %s: expected %h, actual %h",
                           results_checked, label, want, got));
  endfunction

  function automatic logic [7:0] pick_kind();
    case ($urandom_range(0, 17))
      0:  return KIND_UUID16_PART;
      1:  return KIND_UUID16_FULL;
      2:  return KIND_UUID32_PART;
      3:  return KIND_UUID32_FULL;
      4:  return KIND_UUID128_PART;
      5:  return KIND_UUID128_FULL;
      6:  return KIND_SHORT_NAME;
      7:  return KIND_COMPLETE_NAME;
      8:  return KIND_TX_POWER;
      9:  return KIND_SVC_DATA16;
      10: return KIND_SVC_DATA32;
      11: return KIND_SVC_DATA128;
      12: return KIND_MANUFACTURER;
      13: return KIND_TX_POWER;
      14: return KIND_MANUFACTURER;
      15: return KIND_SHORT_NAME;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void add_field(logic [7:0] kind, int vlen);
    pkt_q.push_back(8'(vlen + 1));
    pkt_q.push_back(kind);
    repeat (vlen) pkt_q.push_back(8'($urandom));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = feed_paced ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{data_byte: b, last_byte: last};
    do @(posedge clk); while (in_stall);
    absorb_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_packet();
    for (int i = 0; i < pkt_q.size(); i++) send_byte(pkt_q[i], i == pkt_q.size() - 1);
    pkt_q.delete();
    packets_sent++;
  endtask

  // The limit is only changed once every summary is out and the block is idle.
  task automatic write_name_limit(input logic [7:0] value);
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    name_limit = value;
    cfg_writes++;
  endtask

  task automatic test_directed();
    // Zero length as the only word.
    pkt_q = '{8'h00};
    send_packet();
    // Most negative TX power, then a manufacturer field with no payload.
    pkt_q = '{8'h02, KIND_TX_POWER, 8'h80, 8'h03, KIND_MANUFACTURER, 8'h34, 8'h12};
    send_packet();
    // A complete name is kept over later names; the zero length stops parsing.
    pkt_q = '{8'h03, KIND_COMPLETE_NAME, 8'h41, 8'h42, 8'h02, KIND_SHORT_NAME, 8'h43,
              8'h01, KIND_COMPLETE_NAME, 8'h00, 8'hFF};
    send_packet();
    // The last short name wins, even when it is empty.
    pkt_q = '{8'h02, KIND_SHORT_NAME, 8'h61, 8'h01, KIND_SHORT_NAME};
    send_packet();
    // The packet ends inside a structure.
    pkt_q = '{8'h05, KIND_SVC_DATA16, 8'h01};
    send_packet();
  endtask

  task automatic test_name_limit();
    logic [7:0] lim;
    for (int i = 0; i < 6; i++) begin
      case (i)
        0:       lim = 8'd0;
        1:       lim = 8'd255;
        2:       lim = 8'd1;
        default: lim = 8'($urandom_range(2, 60));
      endcase
      write_name_limit(lim);
      add_field(KIND_SHORT_NAME, $urandom_range(0, 45));
      if ($urandom_range(0, 1) == 1) add_field(KIND_COMPLETE_NAME, $urandom_range(0, 45));
      send_packet();
    end
    write_name_limit(NAME_MAX_LEN_RESET);
  endtask

  task automatic test_long_packets();
    // Exactly 255 words; the last structure ends on the final parsed position.
    add_field(KIND_UUID128_PART, 224);
    add_field(KIND_UUID128_FULL, 16);
    add_field(KIND_TX_POWER, 1);
    add_field(KIND_MANUFACTURER, 6);
    send_packet();
    // Runs past the parse limit; the structure starting at position 254 is lost.
    add_field(KIND_UUID16_FULL, 252);
    pkt_q.push_back(8'h02);
    pkt_q.push_back(KIND_TX_POWER);
    repeat (9) pkt_q.push_back(8'($urandom));
    send_packet();
  endtask

  // Very short packets with no input gaps pile summaries up behind output stalls.
  task automatic test_back_to_back();
    feed_paced = 1'b0;
    repeat (40) begin
      case ($urandom_range(0, 2))
        0: pkt_q.push_back(8'($urandom));
        1: begin
          pkt_q.push_back(8'h01);
          pkt_q.push_back(pick_kind());
        end
        default: add_field(pick_kind(), $urandom_range(1, 2));
      endcase
      send_packet();
    end
    feed_paced = 1'b1;
  endtask

  task automatic test_random_packets();
    int since_cfg;
    int style;
    int vlen;
    since_cfg = 0;
    while (bytes_sent < ITEM_TARGET) begin
      if (since_cfg >= 10) begin
        write_name_limit(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
        since_cfg = 0;
      end
      if ($urandom_range(0, 3) == 0) feed_paced = !feed_paced;
      style = $urandom_range(0, 19);
      if (style < 2) begin
        repeat ($urandom_range(1, 40)) pkt_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(0, 11))
            0:       vlen = 0;
            1:       vlen = 1;
            2:       vlen = 2;
            3:       vlen = 4;
            4:       vlen = 16;
            5:       vlen = 17;
            6:       vlen = $urandom_range(33, 90);
            default: vlen = $urandom_range(0, 20);
          endcase
          add_field(pick_kind(), vlen);
        end
        case (style)
          2, 3: if (pkt_q.size() > 3) repeat ($urandom_range(1, 3)) void'(pkt_q.pop_back());
          4, 5: begin
            pkt_q.push_back(8'h00);
            repeat ($urandom_range(0, 5)) pkt_q.push_back(8'($urandom));
          end
          6: pkt_q.push_back(8'($urandom_range(1, 255)));
          default: ;
        endcase
      end
      if (pkt_q.size() == 0) pkt_q.push_back(8'($urandom));
      send_packet();
      since_cfg++;
    end
  endtask

  initial begin
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    in_word     <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    name_limit  = NAME_MAX_LEN_RESET;
    clear_walk();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_name_limit();
    test_long_packets();
    test_back_to_back();
    test_random_packets();
    in_valid <= 1'b0;
    while (summary_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d packets in %0d payload words across %0d name limit writes.",
             packets_sent, bytes_sent, cfg_writes);
    $display("Checked %0d summary words; %0d errors found.", results_checked, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output side: holds off for a random number of cycles before each summary.
  initial begin
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 7) == 0) sink_paced = !sink_paced;
      hold = sink_paced ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_word_t expected;
    if (!rst && out_valid && !out_stall) begin
      if (summary_q.size() == 0) begin
        note_error("summary word arrived with no packet pending");
      end else begin
        expected = summary_q.pop_front();
        compare_field("tx_power", expected.tx_power, out_word.tx_power);
        compare_field("manufacturer_id", expected.manufacturer_id, out_word.manufacturer_id);
        compare_field("metric_count", expected.metric_count, out_word.metric_count);
        compare_field("has_service", expected.has_service, out_word.has_service);
        compare_field("uuid16_count", expected.uuid16_count, out_word.uuid16_count);
        compare_field("uuid128_count", expected.uuid128_count, out_word.uuid128_count);
        compare_field("name_kind", expected.name_kind, out_word.name_kind);
        compare_field("name_offset", expected.name_offset, out_word.name_offset);
        compare_field("name_len", expected.name_len, out_word.name_len);
        compare_field("mfg_payload_offset", expected.mfg_payload_offset,
                      out_word.mfg_payload_offset);
        compare_field("mfg_payload_len", expected.mfg_payload_len, out_word.mfg_payload_len);
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles.", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
